### sv/sset_pkg.sv
package sset_pkg;

  typedef struct packed {
    logic               func;
    logic signed [31:0] value;
  } req_t;

  typedef struct packed {
    logic [2:0]         status;
    logic signed [31:0] entry_value;
    logic               last;
  } rsp_t;

  typedef enum logic [2:0] {
    ST_INSERTED  = 3'd0,
    ST_DUPLICATE = 3'd1,
    ST_FULL      = 3'd2,
    ST_ENTRY     = 3'd3,
    ST_EMPTY     = 3'd4
  } status_t;

  localparam logic FUNC_INSERT = 1'b0;
  localparam logic FUNC_LIST   = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SEARCH,
    S_SHIFT,
    S_PUT,
    S_LIST,
    S_REPLY
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic    accept;
    logic    idx_inc;
    logic    idx_dec;
    logic    idx_last;
    logic    pos_set;
    logic    pos_end;
    logic    shift_wr;
    logic    put_wr;
    logic    out_load;
    logic    out_entry;
    logic    out_last;
    status_t out_status;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic found_eq;
    logic found_lt;
    logic at_last;
    logic at_pos;
    logic cnt_zero;
    logic cnt_full;
    logic out_free;
  } stat_t;

endpackage

### sv/sset_ctrl.sv
module sset_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  input  logic           req_func,
  output logic           req_stall,
  input  sset_pkg::stat_t stat,
  output sset_pkg::cmd_t  cmd
);

  sset_pkg::state_t  state, state_next;
  sset_pkg::status_t reply, reply_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sset_pkg::S_IDLE;
      reply <= sset_pkg::ST_INSERTED;
    end else begin
      state <= state_next;
      reply <= reply_next;
    end
  end

  always_comb begin
    state_next = state;
    reply_next = reply;
    unique case (state)
      sset_pkg::S_IDLE: begin
        if (req_valid) begin
          if (req_func == sset_pkg::FUNC_LIST) begin
            if (stat.cnt_zero) begin
              reply_next = sset_pkg::ST_EMPTY;
              state_next = sset_pkg::S_REPLY;
            end else begin
              state_next = sset_pkg::S_LIST;
            end
          end else if (stat.cnt_zero) begin
            state_next = sset_pkg::S_PUT;
          end else begin
            state_next = sset_pkg::S_SEARCH;
          end
        end
      end
      sset_pkg::S_SEARCH: begin
        if (stat.found_eq) begin
          reply_next = sset_pkg::ST_DUPLICATE;
          state_next = sset_pkg::S_REPLY;
        end else if (stat.found_lt || stat.at_last) begin
          if (stat.cnt_full) begin
            reply_next = sset_pkg::ST_FULL;
            state_next = sset_pkg::S_REPLY;
          end else if (stat.found_lt) begin
            state_next = sset_pkg::S_SHIFT;
          end else begin
            state_next = sset_pkg::S_PUT;
          end
        end
      end
      sset_pkg::S_SHIFT: begin
        if (stat.at_pos) state_next = sset_pkg::S_PUT;
      end
      sset_pkg::S_PUT: begin
        if (stat.out_free) state_next = sset_pkg::S_IDLE;
      end
      sset_pkg::S_LIST: begin
        if (stat.out_free && stat.at_last) state_next = sset_pkg::S_IDLE;
      end
      sset_pkg::S_REPLY: begin
        if (stat.out_free) state_next = sset_pkg::S_IDLE;
      end
      default: state_next = sset_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd            = '0;
    cmd.out_status = sset_pkg::ST_INSERTED;
    req_stall      = 1'b1;
    unique case (state)
      sset_pkg::S_IDLE: begin
        req_stall  = 1'b0;
        cmd.accept = req_valid;
        // empty store: the new value goes straight to slot zero
        cmd.pos_end = req_valid && (req_func == sset_pkg::FUNC_INSERT) && stat.cnt_zero;
      end
      sset_pkg::S_SEARCH: begin
        if (stat.found_eq) begin
          cmd.idx_inc = 1'b0;
        end else if (stat.found_lt) begin
          cmd.pos_set  = !stat.cnt_full;
          cmd.idx_last = !stat.cnt_full;
        end else if (stat.at_last) begin
          cmd.pos_end = !stat.cnt_full;
        end else begin
          cmd.idx_inc = 1'b1;
        end
      end
      sset_pkg::S_SHIFT: begin
        cmd.shift_wr = 1'b1;
        cmd.idx_dec  = !stat.at_pos;
      end
      sset_pkg::S_PUT: begin
        cmd.put_wr     = stat.out_free;
        cmd.out_load   = stat.out_free;
        cmd.out_last   = 1'b1;
        cmd.out_status = sset_pkg::ST_INSERTED;
      end
      sset_pkg::S_LIST: begin
        cmd.out_load   = stat.out_free;
        cmd.out_entry  = 1'b1;
        cmd.out_last   = stat.at_last;
        cmd.out_status = sset_pkg::ST_ENTRY;
        cmd.idx_inc    = stat.out_free && !stat.at_last;
      end
      sset_pkg::S_REPLY: begin
        cmd.out_load   = stat.out_free;
        cmd.out_last   = 1'b1;
        cmd.out_status = reply;
      end
      default: req_stall = 1'b1;
    endcase
  end

endmodule

### sv/sset_dp.sv
module sset_dp #(
  parameter int CAPACITY = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic signed [31:0] value,
  input  sset_pkg::cmd_t     cmd,
  output sset_pkg::stat_t    stat,
  input  logic               rsp_stall,
  output logic               rsp_valid,
  output sset_pkg::rsp_t     rsp_data
);

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);

  logic signed [31:0] mem [CAPACITY];
  logic signed [31:0] rd_data;
  logic signed [31:0] value_q;

  logic [CW-1:0] count;
  logic [CW-1:0] idx, idx_next;
  logic [CW-1:0] idx_plus;
  logic [CW-1:0] pos;
  logic [CW-1:0] count_less;

  logic          rd_en;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic signed [31:0] wr_data;

  assign idx_plus   = idx + CW'(1);
  assign count_less = count - CW'(1);

  // the read address is the index of the next cycle, so rd_data always matches idx
  always_comb begin
    idx_next = idx;
    if (cmd.accept) begin
      idx_next = '0;
    end else if (cmd.idx_inc) begin
      idx_next = idx_plus;
    end else if (cmd.idx_dec) begin
      idx_next = idx - CW'(1);
    end else if (cmd.idx_last) begin
      idx_next = count_less;
    end
  end

  assign rd_en = idx_next < CW'(CAPACITY);

  always_ff @(posedge clk) begin
    if (rd_en) rd_data <= mem[idx_next[AW-1:0]];
  end

  assign wr_en   = cmd.shift_wr || cmd.put_wr;
  assign wr_addr = cmd.shift_wr ? idx_plus[AW-1:0] : pos[AW-1:0];
  assign wr_data = cmd.shift_wr ? rd_data : value_q;

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
  end

  always_ff @(posedge clk) begin
    idx <= idx_next;
    if (cmd.accept) value_q <= value;
    if (cmd.pos_set) begin
      pos <= idx;
    end else if (cmd.pos_end) begin
      pos <= count;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.put_wr) begin
      count <= count + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.out_load) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      rsp_data.status      <= cmd.out_status;
      rsp_data.entry_value <= cmd.out_entry ? rd_data : 32'sd0;
      rsp_data.last        <= cmd.out_last;
    end
  end

  assign stat.found_eq = rd_data == value_q;
  assign stat.found_lt = rd_data < value_q;
  assign stat.at_last  = idx == count_less;
  assign stat.at_pos   = idx == pos;
  assign stat.cnt_zero = count == '0;
  assign stat.cnt_full = count == CW'(CAPACITY);
  assign stat.out_free = !rsp_valid || !rsp_stall;

endmodule

### sv/sorted_set_insert_descending.sv
// Sorted set of distinct signed 32-bit values, held largest first.
// Request channel (req_valid / req_stall / req_data): func selects insert or
// list; value is the number to insert. One transaction is taken at a time:
// req_stall stays high from acceptance until the last result is loaded.
// Response channel (rsp_valid / rsp_stall / rsp_data): an insert gives one
// result (inserted, duplicate or full); a list gives one result per stored
// value, largest first, or a single empty result. last marks the final one.
// Steps: an insert is accepted in the idle state, searches the stored values
// (skipped when the set is empty), shifts the smaller entries down one slot
// when the value does not go last, and is written in the put state. Duplicate
// and full are found by the search and answered from the reply state. A list
// reads out each stored value; an empty list goes straight to the reply state.
// The entry memory has one read and one write port and is scanned and shifted
// one entry per clock. Each result is presented from the edge that loads it.
// Reset empties the set at once; no clearing pass runs. While the receiver
// stalls, the result is held in the output register and the controller
// waits before loading the next one.
module sorted_set_insert_descending #(
  parameter int CAPACITY = 32
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_stall,
  input  sset_pkg::req_t req_data,
  output logic           rsp_valid,
  input  logic           rsp_stall,
  output sset_pkg::rsp_t rsp_data
);

  sset_pkg::cmd_t  cmd;
  sset_pkg::stat_t stat;

  sset_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_func  (req_data.func),
    .req_stall (req_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  sset_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .value     (req_data.value),
    .cmd       (cmd),
    .stat      (stat),
    .rsp_stall (rsp_stall),
    .rsp_valid (rsp_valid),
    .rsp_data  (rsp_data)
  );

  a_put_not_full: assert property (@(posedge clk) disable iff (rst)
    cmd.put_wr |-> !stat.cnt_full)
    else $error("insert write with a full store");

  a_shift_not_full: assert property (@(posedge clk) disable iff (rst)
    cmd.shift_wr |-> !stat.cnt_full)
    else $error("shift with a full store");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (req_valid && !req_stall) |=> req_stall)
    else $error("request taken while a transaction is in progress");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (!rsp_valid || !rsp_stall))
    else $error("pending result overwritten");

endmodule
